### rtl/mrc_pkg.sv
// ----------------------------------------------------------------------------
// mrc_pkg
// shared types, codes and the crc-16/modbus lookup table
// ----------------------------------------------------------------------------
`default_nettype none

package mrc_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 256;
  localparam int unsigned MIN_FRAME_BYTES = 4;
  localparam int unsigned POS_W           = $clog2(MAX_FRAME_BYTES + 1);

  localparam logic [POS_W-1:0] COUNT_CAP = POS_W'(MAX_FRAME_BYTES);
  localparam logic [POS_W-1:0] MIN_LEN   = POS_W'(MIN_FRAME_BYTES);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_ADDR  = 3'd1,
    ST_FUNC  = 3'd2,
    ST_COUNT = 3'd3,
    ST_CRC   = 3'd4,
    ST_LEN   = 3'd5
  } status_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_SLAVE_ADDRESS       = 2'd0,
    REG_FUNCTION_CODE       = 2'd1,
    REG_EXPECTED_BYTE_COUNT = 2'd2,
    REG_CHECK_BYTE_COUNT    = 2'd3
  } cfg_index_t;

  typedef logic [15:0] crc_table_t [256];

  // reflected table, built at elaboration
  function automatic crc_table_t build_crc_table();
    crc_table_t  tbl;
    logic [15:0] r;
    for (int i = 0; i < 256; i++) begin
      r = 16'(i);
      for (int k = 0; k < 8; k++) begin
        if (r[0]) begin
          r = (r >> 1) ^ CRC_POLY;
        end else begin
          r = r >> 1;
        end
      end
      tbl[i] = r;
    end
    return tbl;
  endfunction

  localparam crc_table_t CRC_TABLE = build_crc_table();

endpackage

`default_nettype wire

### rtl/mrc_in_if.sv
// ----------------------------------------------------------------------------
// mrc_in_if
// frame byte channel: one received byte per item with a last mark
// ----------------------------------------------------------------------------
`default_nettype none

interface mrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

### rtl/mrc_out_if.sv
// ----------------------------------------------------------------------------
// mrc_out_if
// result channel: one check result per frame
// ----------------------------------------------------------------------------
`default_nettype none

interface mrc_out_if;
  logic                     valid;
  logic                     ready;
  logic [2:0]               status;
  logic [15:0]              crc_value;
  logic [mrc_pkg::POS_W-1:0] frame_length;

  modport source (output valid, output status, output crc_value, output frame_length,
                  input ready);
  modport sink   (input valid, input status, input crc_value, input frame_length,
                  output ready);
endinterface

`default_nettype wire

### rtl/modbus_rtu_response_checker.sv
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker
// path: the input register, then the result register for a last byte's result
// throughput: 1 byte per cycle by one table lookup per byte, but a last byte waits on a pending result
// reset: sync active-high rst clears frame state and loads register defaults
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_response_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  mrc_in_if.sink           rx,
  mrc_out_if.source        res,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  localparam int unsigned PW = mrc_pkg::POS_W;

  // configuration registers
  logic [7:0] slave_address;
  logic [7:0] function_code;
  logic [7:0] expected_byte_count;
  logic       check_byte_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address       <= 8'h01;
      function_code       <= 8'h03;
      expected_byte_count <= 8'h08;
      check_byte_count    <= 1'b1;
    end else if (cfg_we) begin
      unique case (mrc_pkg::cfg_index_t'(cfg_index))
        mrc_pkg::REG_SLAVE_ADDRESS:       slave_address       <= cfg_data;
        mrc_pkg::REG_FUNCTION_CODE:       function_code       <= cfg_data;
        mrc_pkg::REG_EXPECTED_BYTE_COUNT: expected_byte_count <= cfg_data;
        mrc_pkg::REG_CHECK_BYTE_COUNT:    check_byte_count    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register: holds one accepted byte until it is processed
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       consume;

  // a byte is processed when it makes no result, or the result slot is free
  assign consume  = s1_valid && (!s1_last || !res.valid || res.ready);
  assign rx.ready = !s1_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      s1_byte <= rx.data_byte;
      s1_last <= rx.last_byte;
    end
  end

  // frame state
  logic [15:0]            crc_register;
  logic [15:0]            held_bytes;
  logic [PW-1:0]          byte_position;
  mrc_pkg::status_t       first_error;

  logic [15:0]            crc_next;
  logic [15:0]            held_next;
  logic [PW-1:0]          pos_next;
  mrc_pkg::status_t       err_next;
  logic [15:0]            crc_out;
  logic                   bad_len;
  mrc_pkg::status_t       status_next;

  always_comb begin
    err_next = first_error;
    // header checks, first error sticks
    if (err_next == mrc_pkg::ST_OK) begin
      if (byte_position == PW'(0) && s1_byte != slave_address) begin
        err_next = mrc_pkg::ST_ADDR;
      end else if (byte_position == PW'(1) && s1_byte != function_code) begin
        err_next = mrc_pkg::ST_FUNC;
      end else if (byte_position == PW'(2) && check_byte_count &&
                   s1_byte != expected_byte_count) begin
        err_next = mrc_pkg::ST_COUNT;
      end
    end

    // the byte leaving the two-byte hold line joins the crc
    if (byte_position >= PW'(2)) begin
      crc_next = (crc_register >> 8) ^
                 mrc_pkg::CRC_TABLE[crc_register[7:0] ^ held_bytes[15:8]];
    end else begin
      crc_next = crc_register;
    end
    held_next = {held_bytes[7:0], s1_byte};

    // count saturates; a byte past the cap marks the frame too long
    if (byte_position >= mrc_pkg::COUNT_CAP) begin
      pos_next = byte_position;
      err_next = mrc_pkg::ST_LEN;
    end else begin
      pos_next = byte_position + PW'(1);
    end

    // table order: low register byte goes on the wire first
    crc_out = {crc_next[7:0], crc_next[15:8]};
    bad_len = (err_next == mrc_pkg::ST_LEN) || (pos_next < mrc_pkg::MIN_LEN);

    if (bad_len) begin
      status_next = mrc_pkg::ST_LEN;
    end else if (err_next != mrc_pkg::ST_OK) begin
      status_next = err_next;
    end else if (held_next != crc_out) begin
      status_next = mrc_pkg::ST_CRC;
    end else begin
      status_next = mrc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_register  <= mrc_pkg::CRC_INIT;
      held_bytes    <= 16'h0000;
      byte_position <= '0;
      first_error   <= mrc_pkg::ST_OK;
    end else if (consume) begin
      if (s1_last) begin
        // frame done, back to a clean frame state
        crc_register  <= mrc_pkg::CRC_INIT;
        held_bytes    <= 16'h0000;
        byte_position <= '0;
        first_error   <= mrc_pkg::ST_OK;
      end else begin
        crc_register  <= crc_next;
        held_bytes    <= held_next;
        byte_position <= pos_next;
        first_error   <= err_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (consume && s1_last) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && s1_last) begin
      res.status       <= status_next;
      res.crc_value    <= crc_out;
      res.frame_length <= pos_next;
    end
  end

  // checks
  assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.frame_length < mrc_pkg::MIN_LEN) |-> res.status == mrc_pkg::ST_LEN)
    else $error("short frame not reported as bad length");

  assert property (@(posedge clk) disable iff (rst)
    consume && s1_last |=> byte_position == '0 && first_error == mrc_pkg::ST_OK)
    else $error("frame state not cleared after last byte");

  assert property (@(posedge clk) disable iff (rst)
    first_error == mrc_pkg::ST_LEN |-> byte_position == mrc_pkg::COUNT_CAP)
    else $error("length error without saturated count");

  assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready && s1_valid && s1_last |-> !rx.ready)
    else $error("last byte would overrun a pending result");

endmodule

`default_nettype wire

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the modbus rtu response checker: frames of bytes
// go in on the rx channel and a scoreboard with its own crc-16 predictor
// works out each frame's status, crc and length and checks every result
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_BYTES    = 35;
  localparam int unsigned HOLD_CYCLES    = 150;
  localparam int unsigned NUM_PHASES     = 6;

  // what the block reports for one frame
  typedef struct packed {
    mrc_pkg::status_t          status;
    logic [15:0]               crc;
    logic [mrc_pkg::POS_W-1:0] len;
  } frame_result_t;

  typedef logic [7:0] frame_t[$];

  // scoreboard: mirrors the checker's frame state and holds the results
  // still owed by the block, oldest first
  class frame_result_tracker;
    logic [7:0]       slave_addr;
    logic [7:0]       func_code;
    logic [7:0]       count_byte;
    logic             count_check;
    logic [15:0]      crc_reg;
    logic [15:0]      held;
    int unsigned      pos;
    mrc_pkg::status_t first_err;
    frame_result_t    owed_results[$];
    int unsigned      fails;

    function new();
      // power-on register values
      slave_addr  = 8'h01;
      func_code   = 8'h03;
      count_byte  = 8'h08;
      count_check = 1'b1;
      fails       = 0;
      clear_frame();
    endfunction

    static function logic [15:0] crc_update(logic [15:0] r, logic [7:0] b);
      logic [15:0] x;
      x = r ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
        x = x[0] ? ((x >> 1) ^ mrc_pkg::CRC_POLY) : (x >> 1);
      end
      return x;
    endfunction

    function void clear_frame();
      crc_reg   = mrc_pkg::CRC_INIT;
      held      = 16'h0000;
      pos       = 0;
      first_err = mrc_pkg::ST_OK;
    endfunction

    function void write_reg(mrc_pkg::cfg_index_t idx, logic [7:0] v);
      case (idx)
        mrc_pkg::REG_SLAVE_ADDRESS:       slave_addr  = v;
        mrc_pkg::REG_FUNCTION_CODE:       func_code   = v;
        mrc_pkg::REG_EXPECTED_BYTE_COUNT: count_byte  = v;
        mrc_pkg::REG_CHECK_BYTE_COUNT:    count_check = v[0];
        default: ;
      endcase
    endfunction

    function void flag(mrc_pkg::status_t code);
      if (first_err == mrc_pkg::ST_OK) first_err = code;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      frame_result_t r;
      logic [15:0]   crc_out;
      if (pos == 0 && b != slave_addr) flag(mrc_pkg::ST_ADDR);
      if (pos == 1 && b != func_code) flag(mrc_pkg::ST_FUNC);
      if (pos == 2 && count_check && b != count_byte) flag(mrc_pkg::ST_COUNT);
      // crc lags two bytes behind so the trailing crc bytes stay out of it
      if (pos >= 2) crc_reg = crc_update(crc_reg, held[15:8]);
      held = {held[7:0], b};
      if (pos >= mrc_pkg::MAX_FRAME_BYTES) first_err = mrc_pkg::ST_LEN;
      else pos++;
      if (!last) return;
      crc_out = {crc_reg[7:0], crc_reg[15:8]};
      r.crc   = crc_out;
      r.len   = mrc_pkg::POS_W'(pos);
      if (first_err == mrc_pkg::ST_LEN || pos < mrc_pkg::MIN_FRAME_BYTES ||
          pos > mrc_pkg::MAX_FRAME_BYTES) r.status = mrc_pkg::ST_LEN;
      else if (first_err != mrc_pkg::ST_OK) r.status = first_err;
      else if (held != crc_out) r.status = mrc_pkg::ST_CRC;
      else r.status = mrc_pkg::ST_OK;
      owed_results = {owed_results, r};
      clear_frame();
    endfunction

    function void report(string field, logic [15:0] exp_v, logic [15:0] act_v);
      fails++;
      $display("%0t mismatch %s: expected %h actual %h", $time, field, exp_v, act_v);
    endfunction

    function void check_result(logic [2:0] st, logic [15:0] crc,
                               logic [mrc_pkg::POS_W-1:0] len);
      frame_result_t e;
      if (owed_results.size() == 0) begin
        fails++;
        $display("%0t result with none owed: status %h crc %h length %h",
                 $time, st, crc, len);
        return;
      end
      e = owed_results.pop_front();
      if (st !== e.status) report("status", 16'(e.status), 16'(st));
      if (crc !== e.crc) report("crc_value", e.crc, crc);
      if (len !== e.len) report("frame_length", 16'(e.len), 16'(len));
    endfunction

    function int unsigned owed();
      return owed_results.size();
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                cfg_we;
  mrc_pkg::cfg_index_t cfg_index;
  logic [7:0]          cfg_data;

  mrc_in_if  rx_if ();
  mrc_out_if res_if ();

  frame_result_tracker tracker = new();

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned hold_left;
  int unsigned bytes_accepted;
  int unsigned quiet_cycles;

  modbus_rtu_response_checker u_dut (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_if),
    .res       (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // receiver: a pending hold-off wins, otherwise random back-pressure
  always @(negedge clk) begin
    if (hold_left > 0) begin
      res_if.ready = 1'b0;
      hold_left--;
    end else begin
      res_if.ready = ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // monitor: inputs are noted before results are checked, so an item and a
  // result on the same edge are handled the same way on every simulator
  always @(posedge clk) begin
    if (!rst) begin
      if (rx_if.valid && rx_if.ready) begin
        tracker.note_byte(rx_if.data_byte, rx_if.last_byte);
        bytes_accepted++;
      end
      if (res_if.valid && res_if.ready)
        tracker.check_result(res_if.status, res_if.crc_value, res_if.frame_length);
    end
  end

  // watchdog: too long without any item moving on either channel
  always @(posedge clk) begin
    if (rst || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t timeout with %0d results owed", $time, tracker.owed());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // one byte; called and returns at a falling edge, valid left high so
  // back-to-back bytes keep it up
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      rx_if.valid = 1'b0;
      @(negedge clk);
    end
    rx_if.valid     = 1'b1;
    rx_if.data_byte = b;
    rx_if.last_byte = last;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_frame(input frame_t f);
    foreach (f[i]) send_byte(f[i], i == f.size() - 1);
  endtask

  // sender stops until every owed result is in, then lets the pipe settle
  task automatic drain();
    rx_if.valid = 1'b0;
    while (tracker.owed() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // register write, only ever issued while the block is idle
  task automatic write_reg(input mrc_pkg::cfg_index_t idx, input logic [7:0] v);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    tracker.write_reg(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_all(input logic [7:0] addr, input logic [7:0] func,
                           input logic [7:0] cnt, input logic [7:0] chk);
    write_reg(mrc_pkg::REG_SLAVE_ADDRESS, addr);
    write_reg(mrc_pkg::REG_FUNCTION_CODE, func);
    write_reg(mrc_pkg::REG_EXPECTED_BYTE_COUNT, cnt);
    write_reg(mrc_pkg::REG_CHECK_BYTE_COUNT, chk);
  endtask

  // append the crc in wire order, low register byte first
  function automatic frame_t with_crc(frame_t f);
    logic [15:0] c;
    c = mrc_pkg::CRC_INIT;
    foreach (f[i]) c = frame_result_tracker::crc_update(c, f[i]);
    f = {f, c[7:0], c[15:8]};
    return f;
  endfunction

  // well-formed response with n data bytes for the current settings
  function automatic frame_t good_frame(int unsigned n);
    frame_t f;
    f = {tracker.slave_addr, tracker.func_code, 8'(n)};
    for (int i = 0; i < n; i++) f = {f, 8'($urandom)};
    return with_crc(f);
  endfunction

  // mostly good frames, then header errors, corrupted bytes, runts and noise
  function automatic frame_t random_frame();
    frame_t      f;
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(99);
    if (kind >= 87) begin
      n = (kind < 93) ? $urandom_range(3, 1) : $urandom_range(20, 1);
      for (int i = 0; i < n; i++) f = {f, 8'($urandom)};
      return f;
    end
    n = tracker.count_check ? tracker.count_byte : $urandom_range(12, 0);
    f = {tracker.slave_addr, tracker.func_code, 8'(n)};
    for (int i = 0; i < n; i++) f = {f, 8'($urandom)};
    // header damage keeps a correct crc so only the header check trips
    if (kind >= 65 && kind < 70) f[0] ^= 8'($urandom_range(255, 1));
    else if (kind >= 70 && kind < 75) f[1] ^= 8'($urandom_range(255, 1));
    else if (kind >= 75 && kind < 80) f[2] ^= 8'($urandom_range(255, 1));
    f = with_crc(f);
    // single bit hit anywhere, usually a crc mismatch
    if (kind >= 80) f[$urandom_range(f.size() - 1)] ^= 8'(8'h01 << $urandom_range(7));
    return f;
  endfunction

  initial begin
    frame_t      f;
    int unsigned phase_start;

    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = mrc_pkg::REG_SLAVE_ADDRESS;
    cfg_data         = 8'h00;
    rx_if.valid      = 1'b0;
    rx_if.data_byte  = 8'h00;
    rx_if.last_byte  = 1'b0;
    res_if.ready     = 1'b0;
    hold_left        = 0;
    bytes_accepted   = 0;
    quiet_cycles     = 0;
    src_idle_pct     = 23;
    snk_idle_pct     = 50;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part on the power-on settings
    // one-byte runt: bad length, crc still at its initial value
    f = {8'h01};
    send_frame(f);
    // three bytes: still too short
    f = {8'h01, 8'h03, 8'h08};
    send_frame(f);
    // minimal frame, but byte 2 is the crc and fails the byte count check
    f = {8'h01, 8'h03};
    send_frame(with_crc(f));
    // wrong slave address
    f = {8'h7F, 8'h03};
    send_frame(with_crc(f));
    drain();

    // byte count check off, upper data bits must be ignored
    write_reg(mrc_pkg::REG_CHECK_BYTE_COUNT, 8'hFE);
    f = {8'h01, 8'h03};
    send_frame(with_crc(f));
    // crc mismatch
    f = {8'h01, 8'h03};
    f = with_crc(f);
    f[3] ^= 8'h01;
    send_frame(f);
    // exception-style function code
    f = {8'h01, 8'h83};
    send_frame(with_crc(f));
    drain();

    // random phases: settings and idling change between them
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      case (phase / 2)
        0: begin src_idle_pct = 23; snk_idle_pct = 50; end
        1: begin src_idle_pct = 50; snk_idle_pct = 23; end
        default: begin src_idle_pct = 0; snk_idle_pct = 0; end
      endcase
      case (phase)
        0: write_all(8'h00, 8'h00, 8'h00, 8'h01);
        1: write_all(8'hFF, 8'hFF, 8'hFF, 8'hFE);
        2: write_all(8'($urandom), 8'($urandom), 8'($urandom_range(10)),
                     {7'($urandom), 1'b1});
        3: write_all(8'($urandom), 8'($urandom), 8'($urandom_range(10)),
                     {7'($urandom), 1'b0});
        4: write_all(8'h11, 8'h04, 8'h02, 8'h01);
        default: write_all(8'($urandom), 8'($urandom), 8'($urandom_range(10)),
                           8'($urandom));
      endcase
      phase_start = bytes_accepted;

      if (phase == 1) begin
        // largest legal frame, then one byte over the limit
        send_frame(good_frame(mrc_pkg::MAX_FRAME_BYTES - 5));
        send_frame(good_frame(mrc_pkg::MAX_FRAME_BYTES - 4));
      end

      if (phase == 4) begin
        // receiver holds off while frames keep coming, so the block backs up
        hold_left = HOLD_CYCLES;
        for (int i = 0; i < 10; i++) send_frame(random_frame());
      end

      while (bytes_accepted - phase_start < PHASE_BYTES) send_frame(random_frame());
    end

    // wind down: everything owed must arrive, then nothing more may show up
    drain();
    repeat (10) @(negedge clk);
    if (tracker.owed() != 0)
      $display("%0t %0d results never arrived", $time, tracker.owed());
    if (tracker.fails == 0 && tracker.owed() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
